[rtl/vgts_pkg.sv]
// vgts_pkg: shared types and codes of the voxel grid trilinear sampler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package vgts_pkg;

	// result status codes
	localparam logic [1:0] ST_QUERY = 2'd0;
	localparam logic [1:0] ST_TAKEN = 2'd1;
	localparam logic [1:0] ST_CLAMP = 2'd2;
	localparam logic [1:0] ST_GRID  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] CFG_SCALE_X  = 3'd3;
	localparam logic [2:0] CFG_SCALE_Y  = 3'd4;
	localparam logic [2:0] CFG_SCALE_Z  = 3'd5;

	// header bytes before voxel data
	localparam logic [2:0] HDR_DONE = 3'd6;

	// last blend operation, last corner read count and last axis
	localparam logic [2:0] OP_LAST = 3'd6;
	localparam logic [3:0] RD_LAST = 4'd8;
	localparam logic [1:0] AXIS_LAST = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic       latch;
		logic       load;
		logic       mul;
		logic       clamp;
		logic [1:0] axis;
		logic       rd;
		logic [3:0] rd_cnt;
		logic       blend;
		logic [2:0] op;
	} vgts_cmd_t;

endpackage
`default_nettype wire

[rtl/vgts_ram.sv]
// vgts_ram: generic single write, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module vgts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/vgts_ctrl.sv]
// vgts_ctrl: sequencing state machine of the sampler
// depends on vgts_pkg
`timescale 1ns / 1ps
`default_nettype none
module vgts_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              action,
	output logic                   busy,
	output logic                   done,
	output vgts_pkg::vgts_cmd_t    cmd
);
	import vgts_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_CLAMP = 3'd3;
	localparam logic [2:0] S_READ  = 3'd4;
	localparam logic [2:0] S_BLEND = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [1:0] axis_q;
	logic [3:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					axis_q <= '0;
					cnt_q  <= '0;
					if (start) begin
						state_q <= action ? S_MUL : S_LOAD;
					end
				end
				S_LOAD:  state_q <= S_DONE;
				S_MUL:   state_q <= S_CLAMP;
				S_CLAMP: begin
					if (axis_q == AXIS_LAST) begin
						state_q <= S_READ;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_READ: begin
					if (cnt_q == RD_LAST) begin
						cnt_q   <= '0;
						state_q <= S_BLEND;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_BLEND: begin
					if (cnt_q[2:0] == OP_LAST) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		cmd        = '0;
		cmd.latch  = (state_q == S_IDLE) && start;
		cmd.load   = (state_q == S_LOAD);
		cmd.mul    = (state_q == S_MUL);
		cmd.clamp  = (state_q == S_CLAMP);
		cmd.axis   = axis_q;
		cmd.rd     = (state_q == S_READ);
		cmd.rd_cnt = cnt_q;
		cmd.blend  = (state_q == S_BLEND);
		cmd.op     = cnt_q[2:0];
	end
endmodule
`default_nettype wire

[rtl/vgts_datapath.sv]
// vgts_datapath: config registers, grid loader, coordinate mapping and blend
// depends on vgts_pkg and vgts_ram
`timescale 1ns / 1ps
`default_nettype none
module vgts_datapath #(
	parameter int MAX_DIM = 64,
	parameter int COORD_FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire vgts_pkg::vgts_cmd_t cmd,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data,
	input  wire logic [7:0]          file_byte,
	input  wire logic signed [31:0]  point_x,
	input  wire logic signed [31:0]  point_y,
	input  wire logic signed [31:0]  point_z,
	output logic [15:0]              density,
	output logic [1:0]               status
);
	import vgts_pkg::*;

	localparam int F     = COORD_FRAC_BITS;
	localparam int XW    = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
	localparam int SW    = $clog2(MAX_DIM + 1);
	localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int GW    = 32 + F;
	localparam int CW    = XW + F;
	localparam int LW    = 18 + F;

	// configuration
	logic [31:0] origin_q [3];
	logic [31:0] scale_q  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				origin_q[i] <= '0;
				scale_q[i]  <= 32'h0001_0000;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ORIGIN_X: origin_q[0] <= cfg_data;
				CFG_ORIGIN_Y: origin_q[1] <= cfg_data;
				CFG_ORIGIN_Z: origin_q[2] <= cfg_data;
				CFG_SCALE_X:  scale_q[0]  <= cfg_data;
				CFG_SCALE_Y:  scale_q[1]  <= cfg_data;
				CFG_SCALE_Z:  scale_q[2]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input beat
	logic [7:0]  byte_q;
	logic [31:0] pt_q [3];

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q <= file_byte;
			pt_q[0] <= point_x;
			pt_q[1] <= point_y;
			pt_q[2] <= point_z;
		end
	end

	// loader state
	logic [SW-1:0] size_q [3];
	logic [2:0]    hc_q;
	logic [7:0]    hi_q;
	logic [XW-1:0] lx_q, ly_q, lz_q;
	logic [15:0]   hdr_v;
	logic [SW-1:0] hdr_size;
	logic          hdr_clamp;
	logic [AW-1:0] waddr;
	logic          we;
	logic [1:0]    load_st;

	always_comb begin
		hdr_v     = {hi_q, byte_q};
		hdr_clamp = 1'b0;
		hdr_size  = SW'(hdr_v);
		if (hdr_v == 16'd0) begin
			hdr_size  = SW'(1);
			hdr_clamp = 1'b1;
		end else if (hdr_v > 16'(MAX_DIM)) begin
			hdr_size  = SW'(MAX_DIM);
			hdr_clamp = 1'b1;
		end
	end

	assign waddr = AW'(lx_q) + AW'(MAX_DIM) * AW'(ly_q)
		+ AW'(MAX_DIM * MAX_DIM) * AW'(lz_q);
	assign we = cmd.load && (hc_q == HDR_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				size_q[i] <= SW'(1);
			end
			hc_q <= '0;
			hi_q <= '0;
			lx_q <= '0;
			ly_q <= '0;
			lz_q <= '0;
		end else if (cmd.load) begin
			if (hc_q != HDR_DONE) begin
				if (!hc_q[0]) begin
					hi_q <= byte_q;
				end else begin
					size_q[hc_q[2:1]] <= hdr_size;
				end
				hc_q <= hc_q + 3'd1;
				if (hc_q == 3'd5) begin
					lx_q <= '0;
					ly_q <= '0;
					lz_q <= '0;
				end
			end else begin
				priority if (SW'(lx_q) + SW'(1) < size_q[0]) begin
					lx_q <= lx_q + XW'(1);
				end else if (SW'(ly_q) + SW'(1) < size_q[1]) begin
					lx_q <= '0;
					ly_q <= ly_q + XW'(1);
				end else if (SW'(lz_q) + SW'(1) < size_q[2]) begin
					lx_q <= '0;
					ly_q <= '0;
					lz_q <= lz_q + XW'(1);
				end else begin
					lx_q <= '0;
					ly_q <= '0;
					lz_q <= '0;
					hc_q <= '0;
				end
			end
		end
	end

	always_comb begin
		load_st = ST_TAKEN;
		if (hc_q != HDR_DONE) begin
			if (hc_q[0] && hdr_clamp) begin
				load_st = ST_CLAMP;
			end
		end else if ((SW'(lx_q) + SW'(1) >= size_q[0])
				&& (SW'(ly_q) + SW'(1) >= size_q[1])
				&& (SW'(lz_q) + SW'(1) >= size_q[2])) begin
			load_st = ST_GRID;
		end
	end

	// coordinate mapping, one axis at a time on a shared multiplier
	logic signed [32:0] diff;
	logic [63:0]        prod_s1;
	logic               nonpos_s1;
	logic [GW-1:0]      g_raw, g_sub, cap;
	logic [CW-1:0]      g_clamped;
	logic [CW-1:0]      g_q [3];
	logic [SW-1:0]      size_ax;

	assign diff = $signed({pt_q[cmd.axis][31], pt_q[cmd.axis]})
		- $signed({origin_q[cmd.axis][31], origin_q[cmd.axis]});

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1   <= 64'(diff[31:0]) * 64'(scale_q[cmd.axis]);
			nonpos_s1 <= diff[32] || (diff == 33'sd0);
		end
	end

	assign size_ax = size_q[cmd.axis];
	assign g_raw   = prod_s1[63:32-F];
	assign g_sub   = g_raw - GW'(1 << (F - 1));
	assign cap     = GW'({XW'(size_ax - SW'(1)), {F{1'b0}}});

	always_comb begin
		priority if (nonpos_s1 || g_raw <= GW'(1 << (F - 1))) begin
			g_clamped = '0;
		end else if (g_sub > cap) begin
			g_clamped = cap[CW-1:0];
		end else begin
			g_clamped = g_sub[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clamp) begin
			g_q[cmd.axis] <= g_clamped;
		end
	end

	// corner reads
	logic [XW-1:0] c0 [3];
	logic [XW-1:0] c1 [3];
	logic [XW-1:0] rx, ry, rz;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata;
	logic [7:0]    vox_q [8];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c0[i] = g_q[i][CW-1:F];
			c1[i] = (SW'(c0[i]) + SW'(1) < size_q[i]) ? c0[i] + XW'(1) : c0[i];
		end
	end

	assign rx    = cmd.rd_cnt[2] ? c1[0] : c0[0];
	assign ry    = cmd.rd_cnt[1] ? c1[1] : c0[1];
	assign rz    = cmd.rd_cnt[0] ? c1[2] : c0[2];
	assign raddr = AW'(rx) + AW'(MAX_DIM) * AW'(ry) + AW'(MAX_DIM * MAX_DIM) * AW'(rz);

	vgts_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(byte_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.rd && cmd.rd_cnt != 4'd0) begin
			vox_q[3'(cmd.rd_cnt - 4'd1)] <= rdata;
		end
	end

	// blend: one lerp a cycle, a + (b - a) * f
	logic [15:0]          op_a, op_b;
	logic [F-1:0]         op_f;
	logic [15:0]          r_q [6];
	logic signed [16:0]   t_dif;
	logic signed [LW-1:0] t_base, t_prod, t_sum;
	logic [15:0]          lerp_res;

	always_comb begin
		op_a = '0;
		op_b = '0;
		op_f = g_q[2][F-1:0];
		unique case (cmd.op)
			3'd0: begin op_a = {vox_q[0], 8'h00}; op_b = {vox_q[1], 8'h00}; end
			3'd1: begin op_a = {vox_q[2], 8'h00}; op_b = {vox_q[3], 8'h00}; end
			3'd2: begin op_a = {vox_q[4], 8'h00}; op_b = {vox_q[5], 8'h00}; end
			3'd3: begin op_a = {vox_q[6], 8'h00}; op_b = {vox_q[7], 8'h00}; end
			3'd4: begin op_a = r_q[0]; op_b = r_q[1]; op_f = g_q[1][F-1:0]; end
			3'd5: begin op_a = r_q[2]; op_b = r_q[3]; op_f = g_q[1][F-1:0]; end
			3'd6: begin op_a = r_q[4]; op_b = r_q[5]; op_f = g_q[0][F-1:0]; end
			default: ;
		endcase
	end

	assign t_dif    = $signed({1'b0, op_b}) - $signed({1'b0, op_a});
	assign t_base   = $signed({2'b00, op_a, {F{1'b0}}});
	assign t_prod   = LW'(t_dif) * LW'($signed({1'b0, op_f}));
	assign t_sum    = t_base + t_prod;
	assign lerp_res = t_sum[F+15:F];

	always_ff @(posedge clk) begin
		if (cmd.blend && cmd.op != OP_LAST) begin
			r_q[cmd.op] <= lerp_res;
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			density <= '0;
			status  <= ST_QUERY;
		end else if (cmd.load) begin
			density <= '0;
			status  <= load_st;
		end else if (cmd.blend && cmd.op == OP_LAST) begin
			density <= lerp_res;
			status  <= ST_QUERY;
		end
	end
endmodule
`default_nettype wire

[rtl/voxel_grid_trilinear_sampler.sv]
// voxel grid trilinear sampler: a load beat takes one header or voxel byte, a query beat
// runs 3 axis multiplies, 8 serial voxel ram reads and 7 blends; busy is high after accept
// through the done cycle, so a new beat is taken only after the last one is done; the
// voxel ram's single read port makes the corner reads serial
// results are one-cycle done strobes with no back-pressure
// reset clears control, sizes and config; voxel ram contents are not cleared
`timescale 1ns / 1ps
`default_nettype none
module voxel_grid_trilinear_sampler #(
	parameter int MAX_DIM = 64,
	parameter int COORD_FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// command beat
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               action,
	input  wire logic [7:0]         file_byte,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] point_z,
	// result beat
	output logic                    done,
	output logic [15:0]             density,
	output logic [1:0]              status,
	// config writes
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import vgts_pkg::*;

	vgts_cmd_t cmd;

	// sequencing: idle, load, per-axis multiply and clamp, corner reads, blend
	vgts_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.action(action),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	// arithmetic, loader state and the voxel ram
	vgts_datapath #(
		.MAX_DIM        (MAX_DIM),
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.file_byte(file_byte),
		.point_x  (point_x),
		.point_y  (point_y),
		.point_z  (point_z),
		.density  (density),
		.status   (status)
	);
endmodule
`default_nettype wire

[rtl/vgts_checker.sv]
// vgts_port_checker: port-level assertions for the sampler, bound to the top level
// depends on vgts_pkg
`timescale 1ns / 1ps
`default_nettype none
module vgts_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [15:0] density,
	input wire logic [1:0]  status
);
	import vgts_pkg::*;

	// accepted beat makes the block busy and gives no result at once
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted beat did not raise busy");

	// a result only while busy, and the block is free right after it
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result outside busy");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block not free after result");

	// answered query never exceeds full-scale density
	a_density_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_QUERY |-> density <= 16'hFF00)
		else $error("density out of range");
endmodule

bind voxel_grid_trilinear_sampler vgts_port_checker u_vgts_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.density(density),
	.status (status)
);
`default_nettype wire

[bench/vgts_checker.sv]
// vgts_checker: predicts and checks every result beat of the voxel grid sampler
// depends on vgts_pkg for status codes and config register indexes
`timescale 1ns / 1ps
module vgts_checker
	import vgts_pkg::*;
#(
	parameter int MAX_DIM = 64,
	parameter int COORD_FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic        action,
	input  wire logic [7:0]  file_byte,
	input  wire logic [31:0] point_x,
	input  wire logic [31:0] point_y,
	input  wire logic [31:0] point_z,
	input  wire logic        done,
	input  wire logic [15:0] density,
	input  wire logic [1:0]  status,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               errors,
	output int               pending
);

	localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam longint unsigned ONE_F = 64'd1 << COORD_FRAC_BITS;

	typedef struct packed {
		logic [15:0] density;
		logic [1:0]  status;
	} sample_t;

	sample_t     sample_q[$];
	logic [7:0]  voxels [0:DEPTH-1];
	int unsigned dim [3];
	int unsigned hdr_cnt, hdr_hi, lx, ly, lz;
	logic [31:0] origin [3];
	logic [31:0] scale [3];

	initial begin
		errors = 0;
		pending = 0;
		for (int i = 0; i < DEPTH; i++) voxels[i] = 8'd0;
	end

	function automatic int unsigned voxel_at(int unsigned x, int unsigned y, int unsigned z);
		return voxels[x + MAX_DIM * (y + MAX_DIM * z)];
	endfunction

	// clamped grid coordinate, fixed point
	function automatic longint unsigned grid_pos(logic [31:0] p, logic [31:0] org,
			logic [31:0] scl, int unsigned sz);
		longint      diff;
		logic [95:0] prod;
		logic [95:0] g;
		logic [95:0] cap;
		diff = longint'($signed(p)) - longint'($signed(org));
		if (diff <= 0) return 0;
		prod = 96'(diff) * 96'(scl);
		g = prod >> (32 - COORD_FRAC_BITS);
		if (g <= 96'(ONE_F >> 1)) return 0;
		g = g - 96'(ONE_F >> 1);
		cap = 96'(sz - 1) << COORD_FRAC_BITS;
		return (g > cap) ? cap[63:0] : g[63:0];
	endfunction

	function automatic longint unsigned mix(longint unsigned a, longint unsigned b,
			longint unsigned f, int sh);
		return (a * (ONE_F - f) + b * f) >> sh;
	endfunction

	function automatic logic [15:0] sample_density(logic [31:0] px, logic [31:0] py,
			logic [31:0] pz);
		longint unsigned gx, gy, gz, fx, fy, fz, a00, a01, a10, a11, w0, w1;
		int unsigned x0, y0, z0, x1, y1, z1;
		int sh;
		gx = grid_pos(px, origin[0], scale[0], dim[0]);
		gy = grid_pos(py, origin[1], scale[1], dim[1]);
		gz = grid_pos(pz, origin[2], scale[2], dim[2]);
		x0 = gx >> COORD_FRAC_BITS;
		y0 = gy >> COORD_FRAC_BITS;
		z0 = gz >> COORD_FRAC_BITS;
		x1 = (x0 + 1 < dim[0]) ? x0 + 1 : x0;
		y1 = (y0 + 1 < dim[1]) ? y0 + 1 : y0;
		z1 = (z0 + 1 < dim[2]) ? z0 + 1 : z0;
		fx = gx & (ONE_F - 1);
		fy = gy & (ONE_F - 1);
		fz = gz & (ONE_F - 1);
		sh = COORD_FRAC_BITS - 8;
		a00 = mix(voxel_at(x0, y0, z0), voxel_at(x0, y0, z1), fz, sh);
		a01 = mix(voxel_at(x0, y1, z0), voxel_at(x0, y1, z1), fz, sh);
		a10 = mix(voxel_at(x1, y0, z0), voxel_at(x1, y0, z1), fz, sh);
		a11 = mix(voxel_at(x1, y1, z0), voxel_at(x1, y1, z1), fz, sh);
		w0 = mix(a00, a01, fy, COORD_FRAC_BITS);
		w1 = mix(a10, a11, fy, COORD_FRAC_BITS);
		return 16'(mix(w0, w1, fx, COORD_FRAC_BITS));
	endfunction

	function automatic logic [1:0] take_byte(int unsigned b);
		int unsigned v;
		logic [1:0] st;
		st = ST_TAKEN;
		if (hdr_cnt < HDR_DONE) begin
			if (hdr_cnt[0] == 1'b0) begin
				hdr_hi = b;
			end else begin
				v = (hdr_hi << 8) | b;
				if (v < 1) begin
					v = 1;
					st = ST_CLAMP;
				end
				if (v > MAX_DIM) begin
					v = MAX_DIM;
					st = ST_CLAMP;
				end
				dim[hdr_cnt >> 1] = v;
			end
			hdr_cnt++;
			if (hdr_cnt == HDR_DONE) begin
				lx = 0;
				ly = 0;
				lz = 0;
			end
			return st;
		end
		voxels[lx + MAX_DIM * (ly + MAX_DIM * lz)] = 8'(b);
		if (lx + 1 < dim[0]) begin
			lx++;
			return ST_TAKEN;
		end
		lx = 0;
		if (ly + 1 < dim[1]) begin
			ly++;
			return ST_TAKEN;
		end
		ly = 0;
		if (lz + 1 < dim[2]) begin
			lz++;
			return ST_TAKEN;
		end
		lz = 0;
		hdr_cnt = 0;
		return ST_GRID;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_t want, got;
		if (!arst_n) begin
			sample_q.delete();
			dim = '{1, 1, 1};
			hdr_cnt = 0;
			hdr_hi = 0;
			lx = 0;
			ly = 0;
			lz = 0;
			origin = '{0, 0, 0};
			scale = '{32'd65536, 32'd65536, 32'd65536};
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ORIGIN_X: origin[0] = cfg_data;
					CFG_ORIGIN_Y: origin[1] = cfg_data;
					CFG_ORIGIN_Z: origin[2] = cfg_data;
					CFG_SCALE_X:  scale[0] = cfg_data;
					CFG_SCALE_Y:  scale[1] = cfg_data;
					CFG_SCALE_Z:  scale[2] = cfg_data;
					default: ;
				endcase
			end
			if (done) begin
				got.density = density;
				got.status = status;
				if (sample_q.size() == 0) begin
					$display("%0t: unexpected result beat density %0d status %0d",
						$time, density, status);
					errors++;
				end else begin
					want = sample_q.pop_front();
					if (got.density !== want.density) begin
						$display("%0t: density expected %0d actual %0d",
							$time, want.density, got.density);
						errors++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				if (action) begin
					want.density = sample_density(point_x, point_y, point_z);
					want.status = ST_QUERY;
				end else begin
					want.density = 16'd0;
					want.status = take_byte(file_byte);
				end
				sample_q.push_back(want);
			end
		end
		pending = sample_q.size();
	end

endmodule

[bench/voxel_grid_trilinear_sampler_tb.sv]
// voxel_grid_trilinear_sampler_tb: stimulus and verdict for the voxel grid sampler
// depends on vgts_pkg, the sampler rtl and vgts_checker
`timescale 1ns / 1ps
module voxel_grid_trilinear_sampler_tb;
	import vgts_pkg::*;

	localparam int MAX_DIM = 64;
	localparam int FB = 16;
	localparam int ITEMS = 1500;
	localparam int LIMIT = 1000000;
	localparam int SETTLE = 40;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        action;
	logic [7:0]  file_byte;
	logic [31:0] point_x, point_y, point_z;
	logic        done;
	logic [15:0] density;
	logic [1:0]  status;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          errors;
	int          pending;
	int          cycles;
	int          items;
	int          burst_left;

	// sizes the block holds right now, as the header bytes set them
	int unsigned dim [3];
	// boxes fully written by a finished grid; queries are sent only while the sizes fit in one of them
	int unsigned box_x[$], box_y[$], box_z[$];
	logic [31:0] origin [3];
	logic [31:0] scale [3];

	voxel_grid_trilinear_sampler #(.MAX_DIM(MAX_DIM), .COORD_FRAC_BITS(FB)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .action(action), .file_byte(file_byte),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.done(done), .density(density), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	vgts_checker #(.MAX_DIM(MAX_DIM), .COORD_FRAC_BITS(FB)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .action(action), .file_byte(file_byte),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.done(done), .density(density), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// one command beat; sender idles between bursts of random length
	task automatic send_beat(logic act, logic [7:0] b, logic [31:0] px, logic [31:0] py,
			logic [31:0] pz);
		if (burst_left == 0) begin
			start = 1'b0;
			// some bursts follow with no gap at all
			if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		start = 1'b1;
		action = act;
		file_byte = b;
		point_x = px;
		point_y = py;
		point_z = pz;
		// busy is stable at the falling edge; low here means the next rising edge accepts
		while (busy) @(negedge clk);
		@(negedge clk);
		start = 1'b0;
		items++;
	endtask

	// hold off until every result beat is back, then let the block settle
	task automatic drain();
		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx < CFG_SCALE_X) origin[idx] = data;
		else scale[idx - CFG_SCALE_X] = data;
	endtask

	// mode 0 reset values, 1 and 2 the extremes, else random moderate values
	task automatic set_phase(int mode);
		logic [31:0] o, s;
		drain();
		for (int a = 0; a < 3; a++) begin
			case (mode)
				0: begin o = 32'd0; s = 32'd65536; end
				1: begin o = 32'h8000_0000; s = 32'hFFFF_FFFF; end
				2: begin o = 32'h7FFF_FFFF; s = 32'd0; end
				default: begin
					o = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
					s = $urandom_range(8192, 1 << 19);
				end
			endcase
			write_reg(3'(CFG_ORIGIN_X + a), o);
			write_reg(3'(CFG_SCALE_X + a), s);
		end
	endtask

	function automatic bit query_ok();
		for (int i = 0; i < box_x.size(); i++)
			if (box_x[i] >= dim[0] && box_y[i] >= dim[1] && box_z[i] >= dim[2]) return 1;
		return 0;
	endfunction

	// point mostly near the grid box, sometimes anywhere
	function automatic logic [31:0] pick_point(int a);
		longint off;
		if ($urandom_range(0, 4) == 0 || scale[a] == 0) return $urandom;
		off = longint'($urandom_range(0, (dim[a] + 2) * 256)) * 256 - 65536;
		off = off * 65536 / longint'(scale[a]);
		return 32'(longint'($signed(origin[a])) + off);
	endfunction

	task automatic query();
		if (query_ok())
			send_beat(1'b1, 8'($urandom), pick_point(0), pick_point(1), pick_point(2));
	endtask

	// header with given 16-bit sizes, then voxels; queries fall in now and then
	task automatic load_grid(logic [15:0] hx, logic [15:0] hy, logic [15:0] hz, bit ends,
			int mix_rate);
		logic [15:0] h [3];
		int unsigned n;
		h = '{hx, hy, hz};
		for (int a = 0; a < 3; a++) begin
			send_beat(1'b0, h[a][15:8], 0, 0, 0);
			if ($urandom_range(0, mix_rate) == 0) query();
			send_beat(1'b0, h[a][7:0], 0, 0, 0);
			dim[a] = (h[a] == 0) ? 1 : (h[a] > MAX_DIM) ? MAX_DIM : h[a];
			if ($urandom_range(0, mix_rate) == 0) query();
		end
		n = dim[0] * dim[1] * dim[2];
		for (int unsigned i = 0; i < n; i++) begin
			send_beat(1'b0, ends ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom), 0, 0, 0);
			if (i + 1 < n && $urandom_range(0, mix_rate) == 0) query();
		end
		box_x.push_back(dim[0]);
		box_y.push_back(dim[1]);
		box_z.push_back(dim[2]);
	endtask

	function automatic logic [15:0] pick_size(bit allow_big);
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return allow_big ? 16'($urandom_range(MAX_DIM + 1, 65535)) : 16'd1;
			2: return allow_big ? 16'(MAX_DIM) : 16'd2;
			3: return allow_big ? 16'(MAX_DIM + 1) : 16'd3;
			default: return 16'($urandom_range(1, 5));
		endcase
	endfunction

	initial begin
		int big, phase;
		logic [15:0] s [3];
		arst_n = 1'b0;
		start = 1'b0;
		action = 1'b0;
		file_byte = '0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		items = 0;
		burst_left = 0;
		dim = '{1, 1, 1};
		origin = '{0, 0, 0};
		scale = '{32'd65536, 32'd65536, 32'd65536};
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: a 2x2x2 grid of alternating 0 and 255, then queries at
		// corners, cell centers, far outside and below the origin
		set_phase(0);
		load_grid(16'd2, 16'd2, 16'd2, 1'b1, 1000);
		send_beat(1'b1, 8'd0, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
		send_beat(1'b1, 8'd0, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000);
		send_beat(1'b1, 8'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_beat(1'b1, 8'd0, 32'h0000_C000, 32'h0001_4000, 32'h0000_9000);
		send_beat(1'b1, 8'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_beat(1'b1, 8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_beat(1'b1, 8'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0002_0000);
		// size clamps: zero and oversized header values
		load_grid(16'd0, 16'hFFFF, 16'd0, 1'b0, 1000);
		for (int i = 0; i < 4; i++) query();

		// random phases, each under its own register setting
		phase = 1;
		while (items < ITEMS) begin
			set_phase(phase % 5);
			phase++;
			for (int g = 0; g < 3 && items < ITEMS; g++) begin
				big = $urandom_range(0, 3);
				for (int a = 0; a < 3; a++) s[a] = pick_size(a == big);
				load_grid(s[0], s[1], s[2], 1'b0, $urandom_range(2, 12));
				repeat ($urandom_range(10, 40)) query();
			end
		end

		drain();
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[voxel_grid_trilinear_sampler.f]
rtl/vgts_pkg.sv
rtl/vgts_ram.sv
rtl/vgts_ctrl.sv
rtl/vgts_datapath.sv
rtl/voxel_grid_trilinear_sampler.sv
rtl/vgts_checker.sv
bench/vgts_checker.sv
bench/voxel_grid_trilinear_sampler_tb.sv
